// ----- rtl/core/utf8_to_utf16_transcoder_top_macros.svh -----
// Assertion macros for the UTF-8 to UTF-16 transcoder.
`ifndef UTF8_TO_UTF16_TRANSCODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define U8U16_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("u8u16 assertion failed");

`define U8U16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("u8u16 assertion failed");

`else

`define U8U16_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define U8U16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/utf8u16_pkg.sv -----
// Types and constants shared by the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
package utf8u16_pkg;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_LEAD = 2'd1;
  localparam logic [1:0] ERR_BAD_CONT = 2'd2;
  localparam logic [1:0] ERR_TOO_BIG  = 2'd3;

  localparam logic [20:0] CP_PAIR_BASE = 21'h010000;
  localparam logic [20:0] CP_LIMIT     = 21'h110000;
  localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;
  localparam logic [1:0]  CONT_TAG     = 2'b10;

  localparam int unsigned QUEUE_DEPTH = 3;

  typedef struct packed {
    logic        last_unit;
    logic [1:0]  error_code;
    logic [15:0] utf16_unit;
  } result_t;

endpackage

// ----- rtl/core/utf8_to_utf16_transcoder_top.sv -----
// UTF-8 to UTF-16 transcoder top level: byte decoder and result queue.
//
// Input stream (s_axis): one UTF-8 byte per word in s_axis_tdata.
// Output stream (m_axis): one UTF-16 code unit per word. m_axis_tuser holds
// the error code (0 ok, 1 bad lead, 2 bad continuation, 3 too large) and
// m_axis_tlast marks the final unit caused by one input byte. An error word
// carries a zero code unit and tlast high.
// Throughput: one byte per cycle while s_axis_tready is high. Lead bytes of
// multi-byte characters give no word; a completed character gives one word,
// or two for a surrogate pair. The words of a byte are written into a
// registered three-entry result queue when the byte is taken; s_axis_tready
// is high while at most one word is queued, or two when the byte cannot
// complete a surrogate pair, so a byte with two words always fits at once.
// Receiver stall: the queue holds its words and fills; s_axis_tready drops
// once the queue is full, or when two words wait and the next byte may
// complete a surrogate pair, until the receiver takes one.
// Reset: clears the decoder state (pending continuation count and partial
// code point) and empties the queue.
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_top_macros.svh"
module utf8_to_utf16_transcoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] utf16_unit
  output logic [1:0]  m_axis_tuser,   // [1:0] error_code
  output logic        m_axis_tlast    // last_unit
);
  import utf8u16_pkg::*;

  logic [1:0]  bytes_left_q, bytes_left_d;
  logic [20:0] partial_q, partial_d;
  logic [1:0]  count_q, count_d;
  result_t     ent_q [QUEUE_DEPTH];
  result_t     ent_d [QUEUE_DEPTH];

  logic        push, pop;
  logic [1:0]  push_n;
  result_t     res0, res1;
  logic [20:0] cp;
  logic        cp_done;
  logic [19:0] pair_off;
  logic [1:0]  base;

  // only the last continuation byte can give a pair
  assign s_axis_tready = (count_q <= 2'd1) || ((count_q == 2'd2) && (bytes_left_q != 2'd1));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = ent_q[0].utf16_unit;
  assign m_axis_tuser  = ent_q[0].error_code;
  assign m_axis_tlast  = ent_q[0].last_unit;

  // byte decode
  always_comb begin
    bytes_left_d = bytes_left_q;
    partial_d    = partial_q;
    push_n       = 2'd0;
    res0         = '0;
    res1         = '0;
    cp           = '0;
    cp_done      = 1'b0;
    pair_off     = '0;
    if (bytes_left_q == 2'd0) begin
      if (!s_axis_tdata[7]) begin
        cp      = {13'd0, s_axis_tdata};
        cp_done = 1'b1;
      end else if (s_axis_tdata[7:5] == 3'b110) begin
        bytes_left_d = 2'd1;
        partial_d    = {16'd0, s_axis_tdata[4:0]};
      end else if (s_axis_tdata[7:4] == 4'b1110) begin
        bytes_left_d = 2'd2;
        partial_d    = {17'd0, s_axis_tdata[3:0]};
      end else if (s_axis_tdata[7:3] == 5'b11110) begin
        bytes_left_d = 2'd3;
        partial_d    = {18'd0, s_axis_tdata[2:0]};
      end else begin
        push_n = 2'd1;
        res0   = '{last_unit: 1'b1, error_code: ERR_BAD_LEAD, utf16_unit: 16'd0};
      end
    end else if (s_axis_tdata[7:6] != CONT_TAG) begin
      bytes_left_d = 2'd0;
      partial_d    = '0;
      push_n       = 2'd1;
      res0         = '{last_unit: 1'b1, error_code: ERR_BAD_CONT, utf16_unit: 16'd0};
    end else begin
      bytes_left_d = bytes_left_q - 2'd1;
      partial_d    = {partial_q[14:0], s_axis_tdata[5:0]};
      if (bytes_left_q == 2'd1) begin
        cp        = partial_d;
        cp_done   = 1'b1;
        partial_d = '0;
      end
    end

    if (cp_done) begin
      pair_off = cp[19:0] - CP_PAIR_BASE[19:0];
      if (cp < CP_PAIR_BASE) begin
        push_n = 2'd1;
        res0   = '{last_unit: 1'b1, error_code: ERR_NONE, utf16_unit: cp[15:0]};
      end else if (cp < CP_LIMIT) begin
        push_n = 2'd2;
        res0   = '{last_unit: 1'b0, error_code: ERR_NONE,
                   utf16_unit: {HI_SURR_TAG, pair_off[19:10]}};
        res1   = '{last_unit: 1'b1, error_code: ERR_NONE,
                   utf16_unit: {LO_SURR_TAG, pair_off[9:0]}};
      end else begin
        push_n = 2'd1;
        res0   = '{last_unit: 1'b1, error_code: ERR_TOO_BIG, utf16_unit: 16'd0};
      end
    end
  end

  // result queue, head always in entry 0
  always_comb begin
    base = count_q - {1'b0, pop};
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && (i < QUEUE_DEPTH - 1)) begin
        ent_d[i] = ent_q[i + 1];
      end else begin
        ent_d[i] = ent_q[i];
      end
    end
    if (push) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if ((push_n != 2'd0) && (i[1:0] == base)) begin
          ent_d[i] = res0;
        end
        if ((push_n == 2'd2) && (i[1:0] == base + 2'd1)) begin
          ent_d[i] = res1;
        end
      end
      count_d = base + push_n;
    end else begin
      count_d = base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      partial_q    <= '0;
      count_q      <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        bytes_left_q <= bytes_left_d;
        partial_q    <= partial_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  `U8U16_ASSERT_IMPL(a_err_word, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser != ERR_NONE), (m_axis_tdata == 16'd0) && m_axis_tlast)
  `U8U16_ASSERT_IMPL(a_hi_surr, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast,
    (m_axis_tdata[15:10] == HI_SURR_TAG) && (m_axis_tuser == ERR_NONE))
  `U8U16_ASSERT_IMPL(a_lo_follows, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast,
    (count_q >= 2'd2) && ent_q[1].last_unit && (ent_q[1].utf16_unit[15:10] == LO_SURR_TAG))
  `U8U16_ASSERT_NEXT(a_pair_fits, clk_i, rst_ni, push && (push_n == 2'd2), count_q >= 2'd2)

endmodule

// ----- tb/testbench.sv -----
// Self-checking stream testbench for the UTF-8 to UTF-16 transcoder with a built-in decoder model.
`timescale 1ns / 1ps
module testbench;
  import utf8u16_pkg::*;

  localparam int          NUM_DIR     = 25;
  localparam int          NUM_RAND    = 2000;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [15:0] HI_BASE     = 16'hD800;
  localparam logic [15:0] LO_BASE     = 16'hDC00;

  typedef struct {
    logic [7:0]  in_byte;
    bit          typed;
    logic [15:0] unit;
    logic [1:0]  err;
  } dir_row_t;

  // typed rows carry their single word (tlast high); others come from the decoder model
  dir_row_t dir_tbl [NUM_DIR] = '{
    '{8'h00, 1'b1, 16'h0000, ERR_NONE},
    '{8'h7F, 1'b1, 16'h007F, ERR_NONE},
    '{8'h80, 1'b1, 16'h0000, ERR_BAD_LEAD},
    '{8'hFF, 1'b1, 16'h0000, ERR_BAD_LEAD},
    '{8'hC0, 1'b0, 16'h0000, ERR_NONE},      // overlong NUL
    '{8'h80, 1'b1, 16'h0000, ERR_NONE},
    '{8'hE2, 1'b0, 16'h0000, ERR_NONE},
    '{8'h82, 1'b0, 16'h0000, ERR_NONE},
    '{8'hAC, 1'b0, 16'h0000, ERR_NONE},
    '{8'hED, 1'b0, 16'h0000, ERR_NONE},      // surrogate-range value, passed as is
    '{8'hA0, 1'b0, 16'h0000, ERR_NONE},
    '{8'h80, 1'b0, 16'h0000, ERR_NONE},
    '{8'hF0, 1'b0, 16'h0000, ERR_NONE},      // surrogate pair
    '{8'h9F, 1'b0, 16'h0000, ERR_NONE},
    '{8'h98, 1'b0, 16'h0000, ERR_NONE},
    '{8'h80, 1'b0, 16'h0000, ERR_NONE},
    '{8'hF7, 1'b0, 16'h0000, ERR_NONE},      // largest 4-byte value, above the limit
    '{8'hBF, 1'b0, 16'h0000, ERR_NONE},
    '{8'hBF, 1'b0, 16'h0000, ERR_NONE},
    '{8'hBF, 1'b1, 16'h0000, ERR_TOO_BIG},
    '{8'hC3, 1'b0, 16'h0000, ERR_NONE},
    '{8'h41, 1'b1, 16'h0000, ERR_BAD_CONT},
    '{8'hE0, 1'b0, 16'h0000, ERR_NONE},
    '{8'hA0, 1'b0, 16'h0000, ERR_NONE},
    '{8'hF8, 1'b1, 16'h0000, ERR_BAD_CONT}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  result_t     exp_units [$];
  logic [7:0]  byte_stream [$];
  logic [1:0]  conts_left = '0;
  logic [20:0] cp_accum   = '0;
  bit          steady     = 1'b0;
  int          errors     = 0;
  int          cycles     = 0;

  utf8_to_utf16_transcoder_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  function automatic void queue_unit(input logic [15:0] unit, input logic [1:0] err,
                                     input logic last, input bit keep);
    result_t r;
    r.utf16_unit = unit;
    r.error_code = err;
    r.last_unit  = last;
    if (keep) exp_units.push_back(r);
  endfunction

  // decoder model: advances state and queues the words one byte causes
  function automatic void decode_byte(input logic [7:0] b, input bit keep);
    logic [20:0] cp;
    logic [20:0] ofs;
    bit          done;
    done = 1'b0;
    cp   = '0;
    if (conts_left == 2'd0) begin
      if (!b[7]) begin
        cp   = {14'd0, b[6:0]};
        done = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        conts_left = 2'd1;
        cp_accum   = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        conts_left = 2'd2;
        cp_accum   = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        conts_left = 2'd3;
        cp_accum   = {18'd0, b[2:0]};
      end else begin
        queue_unit(16'h0000, ERR_BAD_LEAD, 1'b1, keep);
      end
    end else if (b[7:6] != CONT_TAG) begin
      conts_left = 2'd0;
      cp_accum   = '0;
      queue_unit(16'h0000, ERR_BAD_CONT, 1'b1, keep);
    end else begin
      cp_accum   = {cp_accum[14:0], b[5:0]};
      conts_left = conts_left - 2'd1;
      if (conts_left == 2'd0) begin
        cp       = cp_accum;
        cp_accum = '0;
        done     = 1'b1;
      end
    end
    if (done) begin
      if (cp < 21'h010000) begin
        queue_unit(cp[15:0], ERR_NONE, 1'b1, keep);
      end else if (cp < 21'h110000) begin
        ofs = cp - 21'h010000;
        queue_unit(HI_BASE + {6'd0, ofs[19:10]}, ERR_NONE, 1'b0, keep);
        queue_unit(LO_BASE + {6'd0, ofs[9:0]}, ERR_NONE, 1'b1, keep);
      end else begin
        queue_unit(16'h0000, ERR_TOO_BIG, 1'b1, keep);
      end
    end
  endfunction

  // one character, mostly well formed, sometimes truncated, corrupted or preceded by noise
  task automatic add_char();
    int unsigned roll;
    int unsigned n;
    logic [20:0] cp;
    logic [7:0]  seq [4];
    roll = $urandom_range(0, 99);
    cp   = 21'($urandom());
    if (roll < 25) n = 1;
    else if (roll < 45) n = 2;
    else if (roll < 70) n = 3;
    else n = 4;
    if (n == 4 && $urandom_range(0, 1) == 1) cp = 21'h010000 + 21'($urandom_range(0, 'hFFFFF));
    case (n)
      1: seq[0] = {1'b0, cp[6:0]};
      2: seq[0] = {3'b110, cp[10:6]};
      3: seq[0] = {4'b1110, cp[15:12]};
      default: seq[0] = {5'b11110, cp[20:18]};
    endcase
    for (int i = 1; i < 4; i++) seq[i] = {2'b10, 6'(cp >> (6 * (int'(n) - 1 - i)))};
    roll = $urandom_range(0, 99);
    if (roll < 6 && n > 1) n = $urandom_range(1, n - 1);
    else if (roll < 12 && n > 1) seq[$urandom_range(1, n - 1)] = 8'($urandom());
    else if (roll < 18) byte_stream.push_back(8'($urandom()));
    for (int i = 0; i < int'(n); i++) byte_stream.push_back(seq[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    while (!steady && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, !typed);
    if (typed) exp_units.push_back(want);
    @(negedge clk_i);
  endtask

  initial begin
    result_t want;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < NUM_DIR; i++) begin
      want.utf16_unit = dir_tbl[i].unit;
      want.error_code = dir_tbl[i].err;
      want.last_unit  = 1'b1;
      send_byte(dir_tbl[i].in_byte, dir_tbl[i].typed, want);
    end
    while (byte_stream.size() < NUM_RAND) add_char();
    want = '0;
    for (int i = 0; i < byte_stream.size(); i++) begin
      steady = (i >= 900 && i < 1200);
      send_byte(byte_stream[i], 1'b0, want);
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (exp_units.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 38);
    end
  end

  always @(posedge clk_i) begin : word_check
    result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_units.size() == 0) begin
        $error("unexpected word: utf16_unit %h error_code %0d last_unit %0d",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        e = exp_units.pop_front();
        if (m_axis_tdata !== e.utf16_unit) begin
          $error("utf16_unit mismatch: expected %h, got %h", e.utf16_unit, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== e.error_code) begin
          $error("error_code mismatch: expected %0d, got %0d", e.error_code, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== e.last_unit) begin
          $error("last_unit mismatch: expected %0d, got %0d", e.last_unit, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("timeout with %0d words outstanding", exp_units.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
